// File: hdl/tpw_pkg.sv
// ----------------------------------------------------------------------------
// tpw_pkg: shared constants and types of the triplet pt window check
// Register indexes, reset values, the fixed-point curvature constant and the
// result record used by the datapath and its interfaces.
// ----------------------------------------------------------------------------
package tpw_pkg;

	// Default hit coordinate width, two's complement, 1/256 mm.
	localparam int COORD_BITS_DEF = 24;

	// Result and configuration widths.
	localparam int PT_BITS       = 32;
	localparam int FIELD_BITS    = 20;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_PT_MIN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PT_MAX = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIELD  = 2'd2;

	// Register reset values.
	localparam logic [PT_BITS-1:0]    PT_MIN_RST = 32'h0000_0000;
	localparam logic [PT_BITS-1:0]    PT_MAX_RST = 32'hFFFF_FFFF;
	localparam logic [FIELD_BITS-1:0] FIELD_RST  = 20'd196608;

	// 0.00029979 held as KQ / 2^40; the total scale of the result is 2^55.
	localparam int                 KQ_BITS     = 29;
	localparam logic [KQ_BITS-1:0] KQ          = 29'd329622591;
	localparam int                 SCALE_SHIFT = 55;

	// Bit-product budget of one multiplier stage.
	localparam int MUL_BIT_BUDGET = 1024;

	// One result record.
	typedef struct packed {
		logic               compatible;
		logic [PT_BITS-1:0] momentum;
		logic               degenerate;
	} tpw_result_t;

endpackage

// File: hdl/tpw_if.sv
// ----------------------------------------------------------------------------
// tpw_if: channel interfaces of the triplet pt window check
// Hit triplet input, result output and configuration write channels, each
// with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Hit triplet channel.
interface tpw_hit_if #(parameter int COORD_BITS = tpw_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] third_x;
	logic signed [COORD_BITS-1:0] third_y;

	modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
		input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
		output ready);
endinterface

// Result channel.
interface tpw_res_if;
	logic                         valid;
	logic                         ready;
	logic                         compatible;
	logic [tpw_pkg::PT_BITS-1:0]  momentum;
	logic                         degenerate;

	modport source (output valid, compatible, momentum, degenerate, input ready);
	modport sink (input valid, compatible, momentum, degenerate, output ready);
endinterface

// Configuration write channel.
interface tpw_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tpw_pkg::CFG_IDX_BITS-1:0]  index;
	logic [tpw_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/tpw_mul_pipe.sv
// ----------------------------------------------------------------------------
// tpw_mul_pipe: pipelined unsigned multiplier
// Multiplies a by b one digit of b per stage, accumulating shifted partial
// products, and carries a side payload and a valid bit alongside.
// ----------------------------------------------------------------------------
module tpw_mul_pipe #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	input  logic [SW-1:0]    in_side,
	output logic             out_valid,
	output logic [AW+BW-1:0] p,
	output logic [SW-1:0]    out_side
);

	localparam int PW     = AW + BW;
	localparam int DG_RAW = tpw_pkg::MUL_BIT_BUDGET / AW;
	localparam int DGW    = (DG_RAW < 1) ? 1 : ((DG_RAW > 32) ? 32 : DG_RAW);
	localparam int ND     = (BW + DGW - 1) / DGW;
	localparam int BPW    = ND * DGW;
	localparam int PPW    = AW + DGW;

	logic          vld_s  [0:ND];
	logic [PW-1:0] acc_s  [0:ND];
	logic [AW-1:0] a_s    [0:ND];
	logic [BPW-1:0] b_s   [0:ND];
	logic [SW-1:0] side_s [0:ND];

	// Stage zero is the input itself.
	assign vld_s[0]  = in_valid;
	assign acc_s[0]  = '0;
	assign a_s[0]    = a;
	assign b_s[0]    = BPW'(b);
	assign side_s[0] = in_side;

	// One digit of b per stage.
	for (genvar k = 0; k < ND; k++) begin : g_step
		logic [PPW-1:0] pp;

		assign pp = PPW'(a_s[k]) * PPW'(b_s[k][k*DGW +: DGW]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1]  <= acc_s[k] + (PW'(pp) << (k * DGW));
				a_s[k+1]    <= a_s[k];
				b_s[k+1]    <= b_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[ND];
	assign p         = acc_s[ND];
	assign out_side  = side_s[ND];

endmodule

// File: hdl/triplet_pt_window_check_top.sv
// ----------------------------------------------------------------------------
// triplet_pt_window_check_top: three-hit circle transverse momentum cut
// Fits the circle through three transverse hits and checks its pt window.
// ----------------------------------------------------------------------------
// The block takes one hit triplet per clock and returns one result per
// triplet, in order. The pipeline holds the digit stages of the four
// multipliers (13 at 24 bits), and most of it is the 3*COORD_BITS + 3 stage
// square root followed by the 32 stage divider.
// Throughput is one transaction per cycle as long as results are taken; a
// two-entry output buffer keeps the pipeline moving while one result waits.
// Configuration is taken in every cycle and must only change while the
// block is empty. Degenerate (collinear or coincident) hits give momentum 0,
// compatible 1 and the degenerate flag.
// ----------------------------------------------------------------------------
module triplet_pt_window_check_top #(
	parameter int COORD_BITS = tpw_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tpw_hit_if.sink   hits,
	tpw_res_if.source result,
	tpw_cfg_if.sink   cfg
);

	localparam int DFW   = COORD_BITS + 1;
	localparam int PRW   = 2 * DFW;
	localparam int SQW   = 2 * COORD_BITS + 1;
	localparam int DSW   = 2 * COORD_BITS + 2;
	localparam int CRW   = 2 * COORD_BITS + 2;
	localparam int T1W   = 2 * DSW;
	localparam int TW    = 3 * DSW;
	localparam int RW    = TW / 2;
	localparam int SFW   = RW + tpw_pkg::FIELD_BITS;
	localparam int NW    = SFW + tpw_pkg::KQ_BITS;
	localparam int NPW   = NW - tpw_pkg::SCALE_SHIFT;
	localparam int EW    = (NPW > CRW + tpw_pkg::PT_BITS) ? NPW : CRW + tpw_pkg::PT_BITS;
	localparam int QB    = tpw_pkg::PT_BITS;
	localparam int SIDE2 = 1 + CRW;
	localparam int SIDE1 = SIDE2 + DSW;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [tpw_pkg::PT_BITS-1:0]    pt_min_q;
	logic [tpw_pkg::PT_BITS-1:0]    pt_max_q;
	logic [tpw_pkg::FIELD_BITS-1:0] field_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_min_q <= tpw_pkg::PT_MIN_RST;
			pt_max_q <= tpw_pkg::PT_MAX_RST;
			field_q  <= tpw_pkg::FIELD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tpw_pkg::REG_PT_MIN: pt_min_q <= cfg.data;
				tpw_pkg::REG_PT_MAX: pt_max_q <= cfg.data;
				tpw_pkg::REG_FIELD:  field_q  <= cfg.data[tpw_pkg::FIELD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline enable: the whole pipeline moves unless the output buffer
	// is full.
	// ------------------------------------------------------------------
	logic [1:0] cnt_q;
	logic       en;

	assign en         = (cnt_q != 2'd2);
	assign hits.ready = en;

	// Signed helpers for the first multiplier row.
	function automatic logic [SQW-1:0] sq_mag(input logic signed [DFW-1:0] v);
		logic signed [PRW-1:0] w;
		w = PRW'(v);
		return SQW'(w * w);
	endfunction

	function automatic logic signed [PRW-1:0] smul(input logic signed [DFW-1:0] x,
		input logic signed [DFW-1:0] y);
		logic signed [PRW-1:0] xw;
		logic signed [PRW-1:0] yw;
		xw = PRW'(x);
		yw = PRW'(y);
		return xw * yw;
	endfunction

	// ------------------------------------------------------------------
	// Stage 1: difference vectors.
	// ------------------------------------------------------------------
	logic                  v_s1;
	logic signed [DFW-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= hits.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DFW'(hits.second_x) - DFW'(hits.first_x);
			uy_s1 <= DFW'(hits.second_y) - DFW'(hits.first_y);
			vx_s1 <= DFW'(hits.third_x) - DFW'(hits.first_x);
			vy_s1 <= DFW'(hits.third_y) - DFW'(hits.first_y);
			wx_s1 <= DFW'(hits.third_x) - DFW'(hits.second_x);
			wy_s1 <= DFW'(hits.third_y) - DFW'(hits.second_y);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: cross terms and squared components.
	// ------------------------------------------------------------------
	logic                  v_s2;
	logic signed [PRW-1:0] p1_s2, p2_s2;
	logic [SQW-1:0]        sux_s2, suy_s2, svx_s2, svy_s2, swx_s2, swy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2  <= smul(ux_s1, vy_s1);
			p2_s2  <= smul(uy_s1, vx_s1);
			sux_s2 <= sq_mag(ux_s1);
			suy_s2 <= sq_mag(uy_s1);
			svx_s2 <= sq_mag(vx_s1);
			svy_s2 <= sq_mag(vy_s1);
			swx_s2 <= sq_mag(wx_s1);
			swy_s2 <= sq_mag(wy_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: cross product and squared side lengths.
	// ------------------------------------------------------------------
	logic                  v_s3;
	logic signed [PRW:0]   cr_s3;
	logic [DSW-1:0]        d1_s3, d2_s3, d3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s3 <= (PRW+1)'(p1_s2) - (PRW+1)'(p2_s2);
			d1_s3 <= DSW'(sux_s2) + DSW'(suy_s2);
			d2_s3 <= DSW'(swx_s2) + DSW'(swy_s2);
			d3_s3 <= DSW'(svx_s2) + DSW'(svy_s2);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: magnitude of the cross product and the degenerate flag.
	// ------------------------------------------------------------------
	logic           v_s4;
	logic [CRW-1:0] cra_s4;
	logic           deg_s4;
	logic [DSW-1:0] d1_s4, d2_s4, d3_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cra_s4 <= CRW'((cr_s3 < 0) ? -cr_s3 : cr_s3);
			deg_s4 <= (cr_s3 == '0);
			d1_s4  <= d1_s3;
			d2_s4  <= d2_s3;
			d3_s4  <= d3_s3;
		end
	end

	// ------------------------------------------------------------------
	// Product of the three squared side lengths.
	// ------------------------------------------------------------------
	logic             m1_v;
	logic [T1W-1:0]   m1_p;
	logic [SIDE1-1:0] m1_side;
	logic             m2_v;
	logic [TW-1:0]    m2_p;
	logic [SIDE2-1:0] m2_side;

	tpw_mul_pipe #(.AW(DSW), .BW(DSW), .SW(SIDE1)) u_mul_d12 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.a        (d1_s4),
		.b        (d2_s4),
		.in_side  ({deg_s4, cra_s4, d3_s4}),
		.out_valid(m1_v),
		.p        (m1_p),
		.out_side (m1_side)
	);

	tpw_mul_pipe #(.AW(T1W), .BW(DSW), .SW(SIDE2)) u_mul_d123 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (m1_v),
		.a        (m1_p),
		.b        (m1_side[DSW-1:0]),
		.in_side  (m1_side[SIDE1-1:DSW]),
		.out_valid(m2_v),
		.p        (m2_p),
		.out_side (m2_side)
	);

	// ------------------------------------------------------------------
	// Integer square root, one result bit per stage.
	// ------------------------------------------------------------------
	logic             sq_v    [0:RW];
	logic [RW+1:0]    sq_rem  [0:RW];
	logic [RW-1:0]    sq_root [0:RW];
	logic [TW-1:0]    sq_n    [0:RW];
	logic [SIDE2-1:0] sq_side [0:RW];

	assign sq_v[0]    = m2_v;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_n[0]    = m2_p;
	assign sq_side[0] = m2_side;

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		logic [RW+3:0] remf;
		logic [RW+3:0] trial;

		assign remf  = {sq_rem[i], sq_n[i][TW-1 -: 2]};
		assign trial = (RW+4)'({sq_root[i], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else if (en) begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (remf >= trial) begin
					sq_rem[i+1]  <= (RW+2)'(remf - trial);
					sq_root[i+1] <= {sq_root[i][RW-2:0], 1'b1};
				end else begin
					sq_rem[i+1]  <= (RW+2)'(remf);
					sq_root[i+1] <= {sq_root[i][RW-2:0], 1'b0};
				end
				sq_n[i+1]    <= sq_n[i] << 2;
				sq_side[i+1] <= sq_side[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Scale by the field and the curvature constant.
	// ------------------------------------------------------------------
	logic             m3_v;
	logic [SFW-1:0]   m3_p;
	logic [SIDE2-1:0] m3_side;
	logic             m4_v;
	logic [NW-1:0]    m4_p;
	logic [SIDE2-1:0] m4_side;

	tpw_mul_pipe #(.AW(RW), .BW(tpw_pkg::FIELD_BITS), .SW(SIDE2)) u_mul_field (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_v[RW]),
		.a        (sq_root[RW]),
		.b        (field_q),
		.in_side  (sq_side[RW]),
		.out_valid(m3_v),
		.p        (m3_p),
		.out_side (m3_side)
	);

	tpw_mul_pipe #(.AW(SFW), .BW(tpw_pkg::KQ_BITS), .SW(SIDE2)) u_mul_kq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (m3_v),
		.a        (m3_p),
		.b        (tpw_pkg::KQ),
		.in_side  (m3_side),
		.out_valid(m4_v),
		.p        (m4_p),
		.out_side (m4_side)
	);

	// ------------------------------------------------------------------
	// Divider setup: drop the scale bits and test for a quotient that
	// does not fit in the result.
	// ------------------------------------------------------------------
	logic [EW-1:0]  nx;
	logic [CRW-1:0] m4_cra;

	assign nx     = EW'(m4_p >> tpw_pkg::SCALE_SHIFT);
	assign m4_cra = m4_side[CRW-1:0];

	logic           dv_v   [0:QB];
	logic [CRW-1:0] dv_rem [0:QB];
	logic [QB-1:0]  dv_q   [0:QB];
	logic [CRW-1:0] dv_cra [0:QB];
	logic           dv_sat [0:QB];
	logic           dv_deg [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= m4_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem[0] <= CRW'(nx >> QB);
			dv_q[0]   <= nx[QB-1:0];
			dv_cra[0] <= m4_cra;
			dv_sat[0] <= ((nx >> QB) >= EW'(m4_cra));
			dv_deg[0] <= m4_side[SIDE2-1];
		end
	end

	// ------------------------------------------------------------------
	// Restoring division, one quotient bit per stage. The dividend's low
	// bits are shifted out of dv_q as the quotient bits are shifted in.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [CRW:0] remf;

		assign remf = {dv_rem[k], dv_q[k][QB-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (en) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (remf >= {1'b0, dv_cra[k]}) begin
					dv_rem[k+1] <= CRW'(remf - {1'b0, dv_cra[k]});
					dv_q[k+1]   <= {dv_q[k][QB-2:0], 1'b1};
				end else begin
					dv_rem[k+1] <= CRW'(remf);
					dv_q[k+1]   <= {dv_q[k][QB-2:0], 1'b0};
				end
				dv_cra[k+1] <= dv_cra[k];
				dv_sat[k+1] <= dv_sat[k];
				dv_deg[k+1] <= dv_deg[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Saturation, degenerate override and window compare.
	// ------------------------------------------------------------------
	logic [QB-1:0]       pt;
	tpw_pkg::tpw_result_t res_new;

	assign pt = dv_sat[QB] ? '1 : dv_q[QB];

	always_comb begin
		res_new.degenerate = dv_deg[QB];
		res_new.momentum   = dv_deg[QB] ? '0 : pt;
		res_new.compatible = dv_deg[QB] || ((pt >= pt_min_q) && (pt <= pt_max_q));
	end

	// ------------------------------------------------------------------
	// Two-entry output buffer.
	// ------------------------------------------------------------------
	tpw_pkg::tpw_result_t ent0_q, ent1_q;
	logic                 push, pop;

	assign push = en && dv_v[QB];
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= res_new;
			end else begin
				ent1_q <= res_new;
			end
		end else if (pop && !push) begin
			ent0_q <= ent1_q;
		end else if (pop && push) begin
			ent0_q <= res_new;
		end
	end

	assign result.valid      = (cnt_q != 2'd0);
	assign result.compatible = ent0_q.compatible;
	assign result.momentum   = ent0_q.momentum;
	assign result.degenerate = ent0_q.degenerate;

`ifndef SYNTHESIS
	// A degenerate result always carries zero momentum and passes.
	a_deg_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> result.momentum == '0 && result.compatible)
		else $error("degenerate result with momentum or failing window");

	// A passing non-degenerate result lies inside the configured window.
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.degenerate && result.compatible
		|-> result.momentum >= pt_min_q && result.momentum <= pt_max_q)
		else $error("compatible result outside the pt window");

	// No new transaction while the output buffer is full.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !hits.ready)
		else $error("input accepted with a full output buffer");

	// A stalled pipeline keeps its last stage.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv_v[QB]) && $stable(dv_q[QB]))
		else $error("last pipeline stage changed during a stall");
`endif

endmodule
